// ----- rtl/huffman_table_bit_decoder_macros.svh -----
// Assertion helpers shared by the decoder RTL.
// Both expect clk and rst_n in scope.
`ifndef HUFFMAN_TABLE_BIT_DECODER_MACROS_SVH
`define HUFFMAN_TABLE_BIT_DECODER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define HTD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define HTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/htd_pkg.sv -----
package htd_pkg;

  localparam int MAX_CODE_LEN = 12;
  localparam int BYTE_BITS    = 8;
  localparam int ADDR_W       = MAX_CODE_LEN + 1;
  localparam int MEM_DEPTH    = 1 << ADDR_W;
  localparam int LEN_W        = $clog2(MAX_CODE_LEN + 1);
  localparam int ENTRY_W      = BYTE_BITS + 1;
  localparam int LEFT_W       = $clog2(BYTE_BITS);

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_DATA = 1'b1;

  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [MAX_CODE_LEN-1:0] code_t;
  typedef logic [LEN_W-1:0]        len_t;

  typedef struct packed {
    logic       action;
    logic [7:0] entry_symbol;
    logic [11:0] entry_code;
    logic [3:0] entry_length;
    logic [7:0] data_byte;
    logic       is_last;
    logic [3:0] valid_bits;
  } htd_in_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       code_error;
    logic       run_last;
  } htd_out_t;

  typedef enum logic [1:0] {
    HTD_CLEAR,
    HTD_IDLE,
    HTD_LOOK,
    HTD_FIN
  } htd_state_t;

  // Memory address of a code held in the low len bits, with a marker bit above it.
  function automatic addr_t code_addr(input code_t code, input len_t len);
    addr_t marker;
    marker = addr_t'(1) << len;
    return marker | (addr_t'(code) & (marker - addr_t'(1)));
  endfunction

endpackage

// ----- rtl/htd_ram.sv -----
module htd_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read data holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/huffman_table_bit_decoder.sv -----
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid/in_stall   | htd_in_t  (table load or data byte)
// out     | output    | out_valid/out_stall | htd_out_t (symbol or code error)
//
// A table load is written as it is accepted. A data byte is accepted, then looked up bit
// by bit, then flushed: each bit's memory read steers the next.
// After reset a clearing pass writes all 8192 memory entries, one per cycle, before
// the first transaction is accepted.
// A stalled output holds the lookup when a new result finds the output register and the
// pending result both full, and holds the flush until the pending result moves out.
`include "huffman_table_bit_decoder_macros.svh"

module huffman_table_bit_decoder (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  htd_pkg::htd_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output htd_pkg::htd_out_t out_data
);

  import htd_pkg::*;

  htd_state_t state_r, state_nxt;
  addr_t      clr_r, clr_nxt;
  code_t      cb_r, cb_nxt;
  len_t       cl_r, cl_nxt;
  logic [BYTE_BITS-1:0] sh_r, sh_nxt;
  logic [LEFT_W-1:0]    left_r, left_nxt;
  logic       last_r, last_nxt;
  logic       pend_valid_r, pend_valid_nxt;
  logic [7:0] pend_sym_r, pend_sym_nxt;
  logic       pend_err_r, pend_err_nxt;
  logic       out_valid_r, out_valid_nxt;
  htd_out_t   out_data_r, out_data_nxt;

  logic          mem_we;
  addr_t         mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic          mem_re;
  addr_t         mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;

  logic       out_free;
  logic       hit;
  logic       miss_err;
  logic       res;
  logic       hold;
  code_t      base_cb;
  len_t       base_cl;
  logic [3:0] nbits;

  htd_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MEM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign hit      = mem_rdata[BYTE_BITS];
  assign miss_err = !hit && (int'(cl_r) >= MAX_CODE_LEN);
  assign res      = hit || miss_err;
  assign hold     = res && pend_valid_r && !out_free;

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    cb_nxt         = cb_r;
    cl_nxt         = cl_r;
    sh_nxt         = sh_r;
    left_nxt       = left_r;
    last_nxt       = last_r;
    pend_valid_nxt = pend_valid_r;
    pend_sym_nxt   = pend_sym_r;
    pend_err_nxt   = pend_err_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    mem_waddr      = clr_r;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = code_addr(cb_r, cl_r);
    in_stall       = 1'b1;
    base_cb        = cb_r;
    base_cl        = cl_r;
    nbits          = 4'(BYTE_BITS);

    case (state_r)
      HTD_CLEAR: begin
        mem_we  = 1'b1;
        clr_nxt = clr_r + addr_t'(1);
        if (clr_r == addr_t'(MEM_DEPTH - 1)) begin
          state_nxt = HTD_IDLE;
        end
      end

      HTD_IDLE: begin
        in_stall = 1'b0;
        if (in_data.is_last && (int'(in_data.valid_bits) < BYTE_BITS)) begin
          nbits = in_data.valid_bits;
        end
        if (in_valid) begin
          if (in_data.action == ACT_LOAD) begin
            if ((in_data.entry_length != 4'd0) &&
                (int'(in_data.entry_length) <= MAX_CODE_LEN)) begin
              mem_we    = 1'b1;
              mem_waddr = code_addr(code_t'(in_data.entry_code),
                                    len_t'(in_data.entry_length));
              mem_wdata = {1'b1, in_data.entry_symbol};
            end
          end else if (nbits == 4'd0) begin
            if (in_data.is_last) begin
              cb_nxt = '0;
              cl_nxt = '0;
            end
          end else begin
            // Shift in the first bit and start its lookup.
            cb_nxt    = {cb_r[MAX_CODE_LEN-2:0], in_data.data_byte[BYTE_BITS-1]};
            cl_nxt    = cl_r + len_t'(1);
            sh_nxt    = {in_data.data_byte[BYTE_BITS-2:0], 1'b0};
            left_nxt  = LEFT_W'(nbits - 4'd1);
            last_nxt  = in_data.is_last;
            mem_re    = 1'b1;
            mem_raddr = code_addr(cb_nxt, cl_nxt);
            state_nxt = HTD_LOOK;
          end
        end
      end

      HTD_LOOK: begin
        if (!hold) begin
          if (res) begin
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{symbol: pend_sym_r, code_error: pend_err_r,
                                run_last: 1'b0};
            end
            pend_valid_nxt = 1'b1;
            pend_sym_nxt   = hit ? mem_rdata[BYTE_BITS-1:0] : 8'd0;
            pend_err_nxt   = miss_err;
            base_cb        = '0;
            base_cl        = '0;
          end
          if (left_r != '0) begin
            cb_nxt    = {base_cb[MAX_CODE_LEN-2:0], sh_r[BYTE_BITS-1]};
            cl_nxt    = base_cl + len_t'(1);
            sh_nxt    = {sh_r[BYTE_BITS-2:0], 1'b0};
            left_nxt  = left_r - LEFT_W'(1);
            mem_re    = 1'b1;
            mem_raddr = code_addr(cb_nxt, cl_nxt);
          end else begin
            // Drop leftover bits after the final byte.
            cb_nxt    = last_r ? '0 : base_cb;
            cl_nxt    = last_r ? '0 : base_cl;
            state_nxt = HTD_FIN;
          end
        end
      end

      HTD_FIN: begin
        if (!pend_valid_r) begin
          state_nxt = HTD_IDLE;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = '{symbol: pend_sym_r, code_error: pend_err_r,
                             run_last: 1'b1};
          pend_valid_nxt = 1'b0;
          state_nxt      = HTD_IDLE;
        end
      end

      default: begin
        state_nxt = HTD_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= HTD_CLEAR;
      clr_r        <= '0;
      cb_r         <= '0;
      cl_r         <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      cb_r         <= cb_nxt;
      cl_r         <= cl_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r       <= sh_nxt;
    left_r     <= left_nxt;
    last_r     <= last_nxt;
    pend_sym_r <= pend_sym_nxt;
    pend_err_r <= pend_err_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `HTD_ASSERT_SAME(a_len_bound, 1'b1, int'(cl_r) <= MAX_CODE_LEN, "code length past maximum")
  `HTD_ASSERT_SAME(a_clear_quiet, state_r == HTD_CLEAR, !out_valid_r && !pend_valid_r, "result during clearing pass")
  `HTD_ASSERT_SAME(a_idle_flushed, state_r == HTD_IDLE, !pend_valid_r, "pending result left at idle")
  `HTD_ASSERT_NEXT(a_hold_look, (state_r == HTD_LOOK) && hold, (state_r == HTD_LOOK) && $stable(cb_r) && $stable(cl_r), "lookup advanced while output blocked")

endmodule

// ----- tb/htd_decode_checker.sv -----
`timescale 1ns / 1ps

module htd_decode_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  htd_pkg::htd_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  htd_pkg::htd_out_t out_data,
  output int                fail_count,
  output int                pending,
  output int                checked,
  output int                code_errors
);
  import htd_pkg::*;

  logic [ENTRY_W-1:0] table_mem [MEM_DEPTH];
  code_t              code_acc;
  int                 code_cnt;
  htd_out_t           symbol_q [$];
  int                 mism;
  int                 n_checked;
  int                 n_err;

  initial begin
    for (int i = 0; i < MEM_DEPTH; i++) table_mem[i] = '0;
    code_acc  = '0;
    code_cnt  = 0;
    mism      = 0;
    n_checked = 0;
    n_err     = 0;
  end

  // append one predicted result at the tail
  task automatic queue_result(input htd_out_t r);
    symbol_q.insert(symbol_q.size(), r);
  endtask

  task automatic decode_transaction(input htd_in_t t);
    htd_out_t r;
    int       len;
    int       addr;
    int       nbits;
    int       produced;
    logic [ENTRY_W-1:0] hit;
    produced = 0;
    if (t.action == ACT_LOAD) begin
      len = int'(t.entry_length);
      if (len != 0 && len <= MAX_CODE_LEN) begin
        addr = (1 << len) | (int'(t.entry_code) & ((1 << len) - 1));
        table_mem[addr & (MEM_DEPTH - 1)] = {1'b1, t.entry_symbol};
      end
    end else begin
      nbits = BYTE_BITS;
      if (t.is_last)
        nbits = (int'(t.valid_bits) > BYTE_BITS) ? BYTE_BITS : int'(t.valid_bits);
      for (int b = 0; b < nbits; b++) begin
        code_acc = {code_acc[MAX_CODE_LEN-2:0], t.data_byte[BYTE_BITS-1-b]};
        code_cnt++;
        addr = ((1 << code_cnt) | int'(code_acc)) & (MEM_DEPTH - 1);
        hit = table_mem[addr];
        if (hit[BYTE_BITS]) begin
          r.symbol     = hit[BYTE_BITS-1:0];
          r.code_error = 1'b0;
          r.run_last   = 1'b0;
          queue_result(r);
          produced++;
          code_acc = '0;
          code_cnt = 0;
        end else if (code_cnt >= MAX_CODE_LEN) begin
          r.symbol     = '0;
          r.code_error = 1'b1;
          r.run_last   = 1'b0;
          queue_result(r);
          produced++;
          code_acc = '0;
          code_cnt = 0;
        end
      end
      // drop unmatched leftover bits at end of stream
      if (t.is_last) begin
        code_acc = '0;
        code_cnt = 0;
      end
      if (produced > 0) begin
        symbol_q[symbol_q.size() - 1].run_last = 1'b1;
      end
    end
  endtask

  always @(posedge clk) begin : watch
    htd_out_t want;
    if (!rst_n) begin
      code_acc = '0;
      code_cnt = 0;
      symbol_q.delete();
    end else begin
      if (in_valid && !in_stall) decode_transaction(in_data);
      if (out_valid && !out_stall) begin
        n_checked++;
        if (out_data.code_error) n_err++;
        if (symbol_q.size() == 0) begin
          mism++;
          if (mism <= 10)
            $display("%0t: unexpected result: symbol %02h error %0b last %0b", $realtime,
                     out_data.symbol, out_data.code_error, out_data.run_last);
        end else begin
          want = symbol_q.pop_front();
          if (out_data.symbol !== want.symbol || out_data.code_error !== want.code_error ||
              out_data.run_last !== want.run_last) begin
            mism++;
            if (mism <= 10)
              $display("%0t: result %0d: expected symbol %02h error %0b last %0b, got %02h %0b %0b",
                       $realtime, n_checked, want.symbol, want.code_error, want.run_last,
                       out_data.symbol, out_data.code_error, out_data.run_last);
          end
        end
      end
    end
    fail_count  <= mism;
    pending     <= symbol_q.size();
    checked     <= n_checked;
    code_errors <= n_err;
  end

endmodule

// ----- tb/tb_huffman_table_bit_decoder.sv -----
`timescale 1ns / 1ps

module tb_huffman_table_bit_decoder;
  import htd_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 40;
  localparam int MAX_LEAVES  = 48;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  htd_in_t  in_data   = '0;
  logic     out_stall = 1'b0;
  logic     in_stall;
  logic     out_valid;
  htd_out_t out_data;

  int   fail_count;
  int   pending;
  int   checked;
  int   code_errors;

  int   send_idle = 0;
  int   recv_idle = 0;
  logic hold_go   = 1'b0;
  logic long_hold = 1'b0;
  int   n_loads   = 0;
  int   n_bytes   = 0;

  // code tree hanging below prefix "1"; holes are leaves never loaded
  int   leaf_code [MAX_LEAVES];
  int   leaf_len  [MAX_LEAVES];
  bit   leaf_hole [MAX_LEAVES];
  int   n_leaves;

  huffman_table_bit_decoder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  htd_decode_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .pending     (pending),
    .checked     (checked),
    .code_errors (code_errors)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= long_hold || ($urandom_range(99) < recv_idle);
    end
  end

  initial begin
    while (!hold_go) @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_transaction(input htd_in_t t);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic htd_in_t random_fill();
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    return junk[$bits(htd_in_t)-1:0];
  endfunction

  // set code bits above the length at random, the decoder must ignore them
  function automatic logic [11:0] with_junk(input int code, input int len);
    logic [11:0] junk;
    junk = 12'($urandom) << len;
    return junk | 12'(code);
  endfunction

  task automatic load_entry(input logic [7:0] sym, input logic [11:0] code,
                            input logic [3:0] len);
    htd_in_t t;
    t = random_fill();
    t.action       = ACT_LOAD;
    t.entry_symbol = sym;
    t.entry_code   = code;
    t.entry_length = len;
    n_loads++;
    send_transaction(t);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last, input logic [3:0] vbits);
    htd_in_t t;
    t = random_fill();
    t.action     = ACT_DATA;
    t.data_byte  = b;
    t.is_last    = last;
    t.valid_bits = vbits;
    n_bytes++;
    send_transaction(t);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic build_code_tree();
    int i;
    n_leaves     = 1;
    leaf_code[0] = 1;
    leaf_len[0]  = 1;
    repeat ($urandom_range(14, 30)) begin
      i = $urandom_range(n_leaves - 1);
      // favor the newest leaf so some branches reach full depth
      if ($urandom_range(1) == 1) i = n_leaves - 1;
      if (leaf_len[i] < MAX_CODE_LEN && n_leaves < MAX_LEAVES) begin
        leaf_code[n_leaves] = (leaf_code[i] << 1) | 1;
        leaf_len[n_leaves]  = leaf_len[i] + 1;
        leaf_code[i]        = leaf_code[i] << 1;
        leaf_len[i]         = leaf_len[i] + 1;
        n_leaves++;
      end
    end
    for (i = 0; i < n_leaves; i++) leaf_hole[i] = 1'b0;
    repeat (2) leaf_hole[$urandom_range(n_leaves - 1)] = 1'b1;
  endtask

  task automatic run_random_phase(input int budget, input bit full_load);
    int sent;
    int i;
    int len;
    int nb;
    sent = 0;
    if (full_load) begin
      for (i = 0; i < n_leaves; i++) begin
        if (!leaf_hole[i]) begin
          load_entry(8'($urandom), with_junk(leaf_code[i], leaf_len[i]), 4'(leaf_len[i]));
          sent++;
        end
      end
    end
    while (sent < budget) begin
      repeat ($urandom_range(3)) begin
        i = $urandom_range(n_leaves - 1);
        if (!leaf_hole[i]) begin
          load_entry(8'($urandom), with_junk(leaf_code[i], leaf_len[i]), 4'(leaf_len[i]));
          sent++;
        end
      end
      if ($urandom_range(9) < 2) begin
        if ($urandom_range(1) == 1) begin
          len = ($urandom_range(2) == 0) ? 0 : $urandom_range(13, 15);
          load_entry(8'($urandom), 12'($urandom), 4'(len));
        end else begin
          // shadowed by the one-bit "0" code
          len = $urandom_range(2, MAX_CODE_LEN);
          load_entry(8'($urandom), with_junk($urandom_range((1 << (len - 1)) - 1, 0), len),
                     4'(len));
        end
        sent++;
      end
      nb = $urandom_range(3, 16);
      repeat (nb - 1) begin
        send_byte(($urandom_range(7) == 0) ? 8'hFF : 8'($urandom), 1'b0, 4'($urandom));
      end
      send_byte(8'($urandom), ($urandom_range(3) != 0), 4'($urandom_range(15)));
      sent += nb;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle = 18;
    recv_idle <= 75;

    load_entry(8'hA5, 12'hFFE, 4'd1);
    load_entry(8'hFF, 12'hFFF, 4'd12);
    load_entry(8'h3C, 12'h000, 4'd12);
    load_entry(8'h11, 12'h001, 4'd0);
    load_entry(8'h22, 12'h7FF, 4'd13);
    load_entry(8'h33, 12'hFFF, 4'd15);
    send_byte(8'h00, 1'b0, 4'd0);
    send_byte(8'hFF, 1'b0, 4'd15);
    // load in the middle of a code
    load_entry(8'h00, 12'h0AA, 4'd3);
    send_byte(8'hF0, 1'b0, 4'd0);
    send_byte(8'hFF, 1'b0, 4'd0);
    // twelve bits with no match
    send_byte(8'hE0, 1'b0, 4'd0);
    // overwrite "0", then add "01" which "0" always beats
    load_entry(8'hC3, 12'h000, 4'd1);
    load_entry(8'h5A, 12'h001, 4'd2);
    send_byte(8'h40, 1'b1, 4'd8);
    send_byte(8'h00, 1'b1, 4'd3);
    send_byte(8'hE5, 1'b1, 4'd0);
    send_byte(8'h55, 1'b1, 4'd15);
    send_byte(8'h2A, 1'b1, 4'd9);
    load_entry(8'h00, 12'h000, 4'd1);
    send_byte(8'h7F, 1'b0, 4'd0);
    send_byte(8'hF8, 1'b1, 4'd5);
    wait_drained();

    build_code_tree();
    run_random_phase(120, 1'b1);
    wait_drained();

    send_idle = 75;
    recv_idle <= 18;
    run_random_phase(115, 1'b0);
    wait_drained();

    // no idling; hold the output long enough to back up the input
    send_idle = 0;
    recv_idle <= 0;
    hold_go   <= 1'b1;
    run_random_phase(115, 1'b0);
    wait_drained();

    $display("Run covered %0d table loads and %0d data bytes over three idle patterns",
             n_loads, n_bytes);
    $display("and a long output hold; %0d results checked, %0d of them code errors.",
             checked, code_errors);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/htd_pkg.sv
rtl/htd_ram.sv
rtl/huffman_table_bit_decoder.sv
tb/htd_decode_checker.sv
tb/tb_huffman_table_bit_decoder.sv
